// ----- hw/rtl/lgcm_pkg.sv -----
// ----------------------------------------------------------------------------
// lgcm_pkg: shared types and constants for the light gun calibrated mapper
// Field widths, screen limits, deadband and the structs between submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package lgcm_pkg;

  localparam int RAW_W     = 12;   // raw sensor and calibration register width
  localparam int X_W       = 11;   // screen x width
  localparam int Y_W       = 10;   // screen y width
  localparam int Q_W       = 11;   // quotient width, covers both screen limits
  localparam int NUM_W     = Q_W + RAW_W;  // screen * offset
  localparam int CAL_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int AXES      = 4;
  localparam int AXIS_W    = 2;

  localparam logic [Q_W-1:0] SCREEN_WIDTH  = 11'd1360;
  localparam logic [Q_W-1:0] SCREEN_HEIGHT = 11'd768;
  localparam logic [Q_W-1:0] DEADBAND      = 11'd5;

  // calibration register indexes within one gun's group of four
  localparam logic [1:0] CAL_LEFT   = 2'd0;
  localparam logic [1:0] CAL_TOP    = 2'd1;
  localparam logic [1:0] CAL_RIGHT  = 2'd2;
  localparam logic [1:0] CAL_BOTTOM = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [RAW_W-1:0] span;
  } lgcm_prep_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lgcm_div_stat_t;

endpackage : lgcm_pkg

`default_nettype wire

// ----- hw/rtl/light_gun_calibrated_mapper_top.sv -----
// ----------------------------------------------------------------------------
// light_gun_calibrated_mapper_top: two-gun screen mapper
// Two-point calibration with clamp, integer scaling and deadband per axis,
// run axis by axis through one shared divider.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid, in_stall, gun*_raw_x/y          raw positions in
//  out      out_valid, out_stall, gun*_screen_x/y     shown positions out
//  cfg      cfg_we, cfg_index, cfg_data               calibration writes
//
//  The four axes are handled in turn: load (clamp, multiply), 11 divider
//  steps, then the deadband update; an uncalibrated gun skips the divider.
//  The block takes no new item until the last one is through: in_stall is
//  high from the transfer until the result is loaded into the output
//  register, which may wait on out_stall. Reset clears the calibration, the
//  shown values and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module light_gun_calibrated_mapper_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lgcm_pkg::RAW_W-1:0]      gun1_raw_x,
  input  logic [lgcm_pkg::RAW_W-1:0]      gun1_raw_y,
  input  logic [lgcm_pkg::RAW_W-1:0]      gun2_raw_x,
  input  logic [lgcm_pkg::RAW_W-1:0]      gun2_raw_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lgcm_pkg::X_W-1:0]        gun1_screen_x,
  output logic [lgcm_pkg::Y_W-1:0]        gun1_screen_y,
  output logic [lgcm_pkg::X_W-1:0]        gun2_screen_x,
  output logic [lgcm_pkg::Y_W-1:0]        gun2_screen_y,
  input  logic                            cfg_we,
  input  logic [lgcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgcm_pkg::RAW_W-1:0]      cfg_data
);
  import lgcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [RAW_W-1:0]  cal [CAL_REGS];
  logic [RAW_W-1:0]  raw [AXES];
  logic [AXIS_W-1:0] axis;
  logic [X_W-1:0]    shown_x1;
  logic [Y_W-1:0]    shown_y1;
  logic [X_W-1:0]    shown_x2;
  logic [Y_W-1:0]    shown_y2;

  logic              gun;
  logic              is_y;
  logic [RAW_W-1:0]  c_left;
  logic [RAW_W-1:0]  c_top;
  logic [RAW_W-1:0]  c_right;
  logic [RAW_W-1:0]  c_bottom;
  logic              calib;
  logic [RAW_W-1:0]  cur_raw;
  logic [Q_W-1:0]    screen;
  logic [Q_W-1:0]    value;
  logic [Q_W-1:0]    cur_shown;
  logic [Q_W-1:0]    delta;
  logic              upd_take;
  logic              div_start;
  logic              out_load;

  lgcm_prep_t        prep;
  lgcm_div_stat_t    div_stat;
  logic [Q_W-1:0]    quotient;

  assign gun      = axis[1];
  assign is_y     = axis[0];
  assign c_left   = cal[{gun, CAL_LEFT}];
  assign c_top    = cal[{gun, CAL_TOP}];
  assign c_right  = cal[{gun, CAL_RIGHT}];
  assign c_bottom = cal[{gun, CAL_BOTTOM}];
  assign calib    = (c_left != c_right) && (c_top != c_bottom);
  assign cur_raw  = raw[axis];
  assign screen   = is_y ? SCREEN_HEIGHT : SCREEN_WIDTH;

  lgcm_prep u_prep (
    .v    (cur_raw),
    .a    (is_y ? c_top : c_left),
    .b    (is_y ? c_bottom : c_right),
    .is_y (is_y),
    .prep (prep)
  );

  lgcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .prep     (prep),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // value for the current axis and its deadband test
  always_comb begin
    if (calib) begin
      value = quotient;
    end else if (cur_raw > RAW_W'(screen)) begin
      value = screen;
    end else begin
      value = cur_raw[Q_W-1:0];
    end
    case (axis)
      2'd0:    cur_shown = shown_x1;
      2'd1:    cur_shown = Q_W'(shown_y1);
      2'd2:    cur_shown = shown_x2;
      default: cur_shown = Q_W'(shown_y2);
    endcase
    delta    = (cur_shown >= value) ? (cur_shown - value) : (value - cur_shown);
    upd_take = delta > DEADBAND;
  end

  assign in_stall  = (state != S_IDLE);
  assign div_start = (state == S_LOAD) && calib;
  assign out_load  = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOAD;
      S_LOAD: state_next = calib ? S_DIV : S_UPD;
      S_DIV:  if (div_stat.done) state_next = S_UPD;
      S_UPD:  state_next = (axis == AXIS_W'(AXES - 1)) ? S_FIN : S_LOAD;
      S_FIN:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      out_valid <= 1'b0;
      shown_x1  <= '0;
      shown_y1  <= '0;
      shown_x2  <= '0;
      shown_y2  <= '0;
      for (int i = 0; i < CAL_REGS; i++) begin
        cal[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cal[cfg_index] <= cfg_data;
      end
      if (state == S_IDLE) begin
        axis <= '0;
      end else if (state == S_UPD) begin
        axis <= axis + AXIS_W'(1);
        if (upd_take) begin
          case (axis)
            2'd0:    shown_x1 <= value;
            2'd1:    shown_y1 <= value[Y_W-1:0];
            2'd2:    shown_x2 <= value;
            default: shown_y2 <= value[Y_W-1:0];
          endcase
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      raw[0] <= gun1_raw_x;
      raw[1] <= gun1_raw_y;
      raw[2] <= gun2_raw_x;
      raw[3] <= gun2_raw_y;
    end
    if (out_load) begin
      gun1_screen_x <= shown_x1;
      gun1_screen_y <= shown_y1;
      gun2_screen_x <= shown_x2;
      gun2_screen_y <= shown_y2;
    end
  end

endmodule : light_gun_calibrated_mapper_top

`default_nettype wire

// ----- hw/rtl/lgcm_prep.sv -----
// ----------------------------------------------------------------------------
// lgcm_prep: axis clamp and scale front end
// Clamps one raw axis into its calibrated interval (either orientation) and
// forms the dividend screen*offset and the divisor span.
// ----------------------------------------------------------------------------
`default_nettype none

module lgcm_prep (
  input  logic [lgcm_pkg::RAW_W-1:0] v,
  input  logic [lgcm_pkg::RAW_W-1:0] a,
  input  logic [lgcm_pkg::RAW_W-1:0] b,
  input  logic                       is_y,
  output lgcm_pkg::lgcm_prep_t       prep
);
  import lgcm_pkg::*;

  logic [RAW_W-1:0] vc;
  logic [RAW_W-1:0] off;
  logic [RAW_W-1:0] span;
  logic [Q_W-1:0]   screen;

  always_comb begin
    if (a < b) begin
      vc   = (v < a) ? a : ((v > b) ? b : v);
      off  = vc - a;
      span = b - a;
    end else begin
      vc   = (v > a) ? a : ((v < b) ? b : v);
      off  = a - vc;
      span = a - b;
    end
    screen    = is_y ? SCREEN_HEIGHT : SCREEN_WIDTH;
    prep.num  = NUM_W'(screen) * NUM_W'(off);
    prep.span = span;
  end

endmodule : lgcm_prep

`default_nettype wire

// ----- hw/rtl/lgcm_div.sv -----
// ----------------------------------------------------------------------------
// lgcm_div: iterative restoring divider
// One quotient bit per cycle. The quotient is known to fit Q_W bits, so the
// upper dividend bits seed the remainder and only Q_W steps are run.
// ----------------------------------------------------------------------------
`default_nettype none

module lgcm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  lgcm_pkg::lgcm_prep_t       prep,
  output logic [lgcm_pkg::Q_W-1:0]   quotient,
  output lgcm_pkg::lgcm_div_stat_t   stat
);
  import lgcm_pkg::*;

  logic [RAW_W-1:0] rem;
  logic [RAW_W-1:0] rem_next;
  logic [RAW_W-1:0] span;
  logic [Q_W-1:0]   q;
  logic [3:0]       cnt;
  logic [RAW_W:0]   shifted;
  logic [RAW_W-1:0] diff;
  logic             ge;

  // when ge holds the difference is below span, so the low bits are exact
  always_comb begin
    shifted  = {rem, q[Q_W-1]};
    ge       = shifted >= {1'b0, span};
    diff     = shifted[RAW_W-1:0] - span;
    rem_next = ge ? diff : shifted[RAW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (stat.busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'(Q_W - 1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= prep.num[NUM_W-1:Q_W];
      q    <= prep.num[Q_W-1:0];
      span <= prep.span;
    end else if (stat.busy) begin
      rem <= rem_next;
      q   <= {q[Q_W-2:0], ge};
    end
  end

  assign quotient = q;

endmodule : lgcm_div

`default_nettype wire
